/* rtl/nimc_pkg.sv */
package nimc_pkg;

   localparam int COMMAND_W  = 1;
   localparam int LINE_W     = 7;
   localparam int COUNT_W    = 32;
   localparam int ACTION_W   = 2;
   localparam int BANK_W     = 2;
   localparam int BITPOS_W   = 5;

   localparam int NUM_LINES_DEF = 96;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'h8000_0000;

   // command codes
   localparam logic [COMMAND_W-1:0] CMD_MASK   = 1'b0;
   localparam logic [COMMAND_W-1:0] CMD_UNMASK = 1'b1;

   // status codes
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // line action codes
   localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DISABLE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ENABLE  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the incoming request
      logic commit;   // write back the count for a valid line and load the result register
   } nimc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free; // result register empty or being taken this cycle
   } nimc_sts_type;

endpackage

/* rtl/nimc_req_if.sv */
interface nimc_req_if
   import nimc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [COMMAND_W-1:0] command;
   logic [LINE_W-1:0]    line;

   modport source (output valid, output command, output line, input ready);
   modport sink   (input valid, input command, input line, output ready);
endinterface

/* rtl/nimc_rsp_if.sv */
interface nimc_rsp_if
   import nimc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                status;
   logic [COUNT_W-1:0]  nest_count;
   logic [ACTION_W-1:0] line_action;
   logic [BANK_W-1:0]   bank;
   logic [BITPOS_W-1:0] bit_position;

   modport source (output valid, output status, output nest_count, output line_action,
                   output bank, output bit_position, input ready);
   modport sink   (input valid, input status, input nest_count, input line_action,
                   input bank, input bit_position, output ready);
endinterface

/* rtl/nested_irq_mask_counter.sv */
// channel   dir   handshake      payload
// req       in    valid/ready    command[0:0], line[6:0]
// rsp       out   valid/ready    status, nest_count[31:0], line_action[1:0],
//                                bank[1:0], bit_position[4:0]
//
// one request passes through accept, count store read, then update and write back
// the count store read is a step of its own, as the count store has a registered read port
// a new request is taken while the previous result still waits in the output register
// if that result is not taken, the update waits and req.ready stays low
// reset is synchronous; per-line valid bits clear at once, so no clearing pass
module nested_irq_mask_counter
   import nimc_pkg::*;
#(
   parameter int NUM_LINES = NUM_LINES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   nimc_req_if.sink   req,
   nimc_rsp_if.source rsp
);

   nimc_cmd_type cmd;
   nimc_sts_type sts;

   nimc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nimc_dp #(
      .NUM_LINES (NUM_LINES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req.command),
      .req_line         (req.line),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_status       (rsp.status),
      .rsp_nest_count   (rsp.nest_count),
      .rsp_line_action  (rsp.line_action),
      .rsp_bank         (rsp.bank),
      .rsp_bit_position (rsp.bit_position)
   );

endmodule

/* rtl/nimc_ctrl.sv */
module nimc_ctrl
   import nimc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  nimc_sts_type sts,
   output nimc_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = (state_ff == ST_CALC) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            // hold here until the result register can take the result
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/nimc_dp.sv */
module nimc_dp
   import nimc_pkg::*;
#(
   parameter int NUM_LINES = NUM_LINES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nimc_cmd_type         cmd,
   output nimc_sts_type         sts,
   input  logic [COMMAND_W-1:0] req_command,
   input  logic [LINE_W-1:0]    req_line,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_status,
   output logic [COUNT_W-1:0]   rsp_nest_count,
   output logic [ACTION_W-1:0]  rsp_line_action,
   output logic [BANK_W-1:0]    rsp_bank,
   output logic [BITPOS_W-1:0]  rsp_bit_position
);

   localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(NUM_LINES);

   logic [COUNT_W-1:0]   mem [NUM_LINES];
   logic [NUM_LINES-1:0] valid_ff;
   logic [COUNT_W-1:0]   rd_data_ff;

   logic [COMMAND_W-1:0] command_ff;
   logic [LINE_W-1:0]    line_ff;

   logic                 rsp_valid_ff;
   logic                 status_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ACTION_W-1:0]  action_ff;
   logic [BANK_W-1:0]    bank_ff;
   logic [BITPOS_W-1:0]  bitpos_ff;

   logic [IDX_W-1:0]     idx;
   logic                 line_ok;
   logic [COUNT_W-1:0]   count_old;
   logic [COUNT_W-1:0]   count_new;
   logic [ACTION_W-1:0]  action_new;

   assign idx     = line_ff[IDX_W-1:0];
   assign line_ok = (line_ff < LINE_LIMIT);

   // entries never written since reset read as zero
   assign count_old = valid_ff[idx] ? rd_data_ff : '0;

   always_comb begin
      count_new  = count_old;
      action_new = ACT_NONE;
      case (command_ff)
         CMD_MASK: begin
            if (count_old < COUNT_LIMIT) count_new = count_old + COUNT_W'(1);
            action_new = ACT_DISABLE;
         end
         CMD_UNMASK: begin
            if (count_old != '0) count_new = count_old - COUNT_W'(1);
            action_new = (count_new == '0) ? ACT_ENABLE : ACT_NONE;
         end
         default: begin
            count_new  = count_old;
            action_new = ACT_NONE;
         end
      endcase
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         line_ff    <= req_line;
      end
   end

   // count store, registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx];
      if (cmd.commit && line_ok) begin
         mem[idx] <= count_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && line_ok) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // bank is line[6:5] and bit position line[4:0] for every valid line
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (line_ok) begin
            status_ff <= STATUS_DONE;
            count_ff  <= count_new;
            action_ff <= action_new;
            bank_ff   <= line_ff[LINE_W-1:BITPOS_W];
            bitpos_ff <= line_ff[BITPOS_W-1:0];
         end else begin
            status_ff <= STATUS_INVALID;
            count_ff  <= '0;
            action_ff <= ACT_NONE;
            bank_ff   <= '0;
            bitpos_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_nest_count   = count_ff;
   assign rsp_line_action  = action_ff;
   assign rsp_bank         = bank_ff;
   assign rsp_bit_position = bitpos_ff;

endmodule
